[rtl/core/array_list_engine_assert.svh]
// ----------------------------------------------------------------------------
// array_list_engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define ALE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ale_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg
// Shared constants, op codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DEF_CAPACITY = 128;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 8;

    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_LAST   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_AT     = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH_DEL = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request, clear result
        logic append;    // write value at count, count + 1
        logic dec;       // count - 1
        logic set_ok;
        logic ptr_zero;  // start scan at entry 0
        logic ptr_pin;   // start shift at position_in + 1
        logic hit;       // record match, start shift after it
        logic rd_en;     // read entry at ptr, advance ptr
        logic shift_wr;  // write read data one place down
        logic publish;   // load output register
    } ale_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            pin_ok;
        logic            ptr_end;
        logic            rv;
        logic            match;
    } ale_status_t;

endpackage

[rtl/core/ale_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_req_if
// Request channel: valid/ready with op, value and position.
// ----------------------------------------------------------------------------
interface ale_req_if;
    logic                                valid;
    logic                                ready;
    logic [ale_pkg::OP_W-1:0]            op;
    logic signed [ale_pkg::VALUE_W-1:0]  value;
    logic [ale_pkg::POS_W-1:0]           position_in;

    modport source (output valid, output op, output value, output position_in, input ready);
    modport sink   (input valid, input op, input value, input position_in, output ready);
endinterface

[rtl/core/ale_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_rsp_if
// Result channel: valid/ready with flag, position and count.
// ----------------------------------------------------------------------------
interface ale_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [ale_pkg::POS_W-1:0]    position_out;
    logic [ale_pkg::COUNT_W-1:0]  count_out;

    modport source (output valid, output ok, output position_out, output count_out, input ready);
    modport sink   (input valid, input ok, input position_out, input count_out, output ready);
endinterface

[rtl/core/array_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine
// Packed list of signed 32-bit values with append, remove and search.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per request: op, value, position_in. It is taken
//   when valid and ready are high at a clock edge; ready is high only while
//   the sequencer is idle, so one request is worked on at a time and the
//   next one is taken only once the last result is in the output register.
//   rsp carries one item per request: ok, position_out, count_out.
//   Append, remove last, an unknown op and an index out of range finish
//   straight after dispatch. A search walks up from entry 0 until the first
//   match or the end of the list; a remove at index shifts every entry above
//   it one place down; a search+remove scans, then shifts on a hit.
//   The walks read the entry memory one entry per cycle.
//   Reset (rst_n low) empties the list and drops any pending result; the
//   entry memory itself is not cleared, only entries below count are read.
//   A result sits in the output register until rsp.ready; meanwhile the
//   next request is accepted and worked on, and it waits only at the very
//   end for the output register to free up.
// ----------------------------------------------------------------------------
module array_list_engine
#(
    parameter int CAPACITY = ale_pkg::DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    ale_req_if.sink   req,
    ale_rsp_if.source rsp
);

    // command / status link between sequencer and datapath
    ale_pkg::ale_cmd_t    cmd;
    ale_pkg::ale_status_t status;

    ale_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // memory, count, scan pointer and output register
    ale_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (req.op),
        .value        (req.value),
        .position_in  (req.position_in),
        .ok           (rsp.ok),
        .position_out (rsp.position_out),
        .count_out    (rsp.count_out)
    );

endmodule

[rtl/core/ale_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_ctrl
// Sequencer: dispatches a request, runs scan and shift walks, hands result.
// ----------------------------------------------------------------------------
`include "array_list_engine_assert.svh"

module ale_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ale_pkg::ale_status_t  status,
    output ale_pkg::ale_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_FIN;
                unique case (status.op) inside
                    ale_pkg::OP_APPEND:
                    begin
                        if (!status.full)
                        begin
                            cmd.append = 1'b1;
                            cmd.set_ok = 1'b1;
                        end
                    end
                    ale_pkg::OP_DEL_LAST:
                    begin
                        if (!status.empty)
                        begin
                            cmd.dec    = 1'b1;
                            cmd.set_ok = 1'b1;
                        end
                    end
                    ale_pkg::OP_DEL_AT:
                    begin
                        if (status.pin_ok)
                        begin
                            cmd.ptr_pin = 1'b1;
                            state_next  = S_SHIFT;
                        end
                    end
                    ale_pkg::OP_SEARCH, ale_pkg::OP_SEARCH_DEL:
                    begin
                        cmd.ptr_zero = 1'b1;
                        state_next   = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = (status.op == ale_pkg::OP_SEARCH) ? S_FIN : S_SHIFT;
                end
                else if (status.ptr_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_wr = status.rv;
                if (!status.ptr_end)
                begin
                    cmd.rd_en = 1'b1;
                end
                else if (!status.rv)
                begin
                    cmd.dec    = 1'b1;
                    cmd.set_ok = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `ALE_ASSERT_IMP(a_publish_slot_free, cmd.publish, !out_valid_reg || out_ready, "result overwritten before taken")
    `ALE_ASSERT_NEXT(a_publish_shows, cmd.publish, out_valid_reg && state_reg == S_IDLE, "published result not shown")
    `ALE_ASSERT_IMP(a_rv_in_walk, status.rv, state_reg == S_SCAN || state_reg == S_SHIFT, "read data outside a walk")

endmodule

[rtl/core/ale_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_dpath
// Entry memory, count, walk pointer, comparator and result register.
// ----------------------------------------------------------------------------
`include "array_list_engine_assert.svh"

module ale_dpath
#(
    parameter int CAPACITY = ale_pkg::DEF_CAPACITY
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ale_pkg::ale_cmd_t                   cmd,
    output ale_pkg::ale_status_t                status,
    input  logic [ale_pkg::OP_W-1:0]            op,
    input  logic signed [ale_pkg::VALUE_W-1:0]  value,
    input  logic [ale_pkg::POS_W-1:0]           position_in,
    output logic                                ok,
    output logic [ale_pkg::POS_W-1:0]           position_out,
    output logic [ale_pkg::COUNT_W-1:0]         count_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > ale_pkg::POS_W) ? CW : ale_pkg::POS_W;

    logic signed [ale_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [ale_pkg::OP_W-1:0]            op_reg;
    logic signed [ale_pkg::VALUE_W-1:0]  value_reg;
    logic [ale_pkg::POS_W-1:0]           pin_reg;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       ptr_reg;
    logic [CW-1:0]                       raddr_reg;
    logic                                rv_reg;
    logic signed [ale_pkg::VALUE_W-1:0]  rdata_reg;
    logic                                ok_reg;
    logic [AW-1:0]                       pos_reg;
    logic                                res_ok_reg;
    logic [ale_pkg::POS_W-1:0]           res_pos_reg;
    logic [ale_pkg::COUNT_W-1:0]         res_count_reg;

    logic                                we;
    logic [AW-1:0]                       wa;
    logic signed [ale_pkg::VALUE_W-1:0]  wd;
    logic [CW-1:0]                       raddr_dec;

    // shift writes land one place below the address the data came from
    assign raddr_dec = raddr_reg - CW'(1);
    assign we        = cmd.append || cmd.shift_wr;
    assign wa        = cmd.append ? count_reg[AW-1:0] : raddr_dec[AW-1:0];
    assign wd        = cmd.append ? value_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            value_reg <= value;
            pin_reg   <= position_in;
        end
        if (cmd.rd_en)
        begin
            raddr_reg <= ptr_reg;
        end
        if (cmd.capture)
        begin
            pos_reg <= '0;
        end
        else if (cmd.hit)
        begin
            pos_reg <= raddr_reg[AW-1:0];
        end
        if (cmd.ptr_zero)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.ptr_pin)
        begin
            ptr_reg <= CW'(pin_reg) + CW'(1);
        end
        else if (cmd.hit)
        begin
            ptr_reg <= raddr_reg + CW'(1);
        end
        else if (cmd.rd_en)
        begin
            ptr_reg <= ptr_reg + CW'(1);
        end
        if (cmd.publish)
        begin
            res_ok_reg    <= ok_reg;
            res_pos_reg   <= ale_pkg::POS_W'(pos_reg);
            res_count_reg <= ale_pkg::COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rv_reg    <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            rv_reg <= cmd.rd_en;
            if (cmd.append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.capture)
            begin
                ok_reg <= 1'b0;
            end
            else if (cmd.set_ok || cmd.hit)
            begin
                ok_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        status         = '0;
        status.op      = op_reg;
        status.full    = (count_reg == CW'(CAPACITY));
        status.empty   = (count_reg == '0);
        status.pin_ok  = (PW'(pin_reg) < PW'(count_reg));
        status.ptr_end = (ptr_reg >= count_reg);
        status.rv      = rv_reg;
        status.match   = rv_reg && (rdata_reg == value_reg);
    end

    assign ok           = res_ok_reg;
    assign position_out = res_pos_reg;
    assign count_out    = res_count_reg;

    `ALE_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `ALE_ASSERT_IMP(a_one_writer, cmd.append, !cmd.shift_wr, "two memory writes in one cycle")
    `ALE_ASSERT_IMP(a_read_in_range, cmd.rd_en, ptr_reg < CW'(CAPACITY), "read beyond capacity")

endmodule

[sim/tb_array_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_list_engine
// Self-checking bench for the packed list engine. A short table of requests
// with hand-worked results covers the empty, out-of-range, no-match and
// reserved-op cases. A fill to capacity with a refused append follows, then biased random traffic
// checked against a behavioural copy of the list kept in the bench.
// ----------------------------------------------------------------------------
module tb_array_list_engine;

    localparam int LIST_CAP     = ale_pkg::DEF_CAPACITY;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = LIST_CAP + 20;   // longest walk plus overhead
    localparam int LONG_HOLD    = 400;             // result side stall, cycles
    localparam int RANDOM_ITEMS = 640;
    localparam int CALM_ITEMS   = 100;             // tail of the run, no idling
    localparam int PHASE_LEN    = 60;

    // op codes the block ignores
    localparam logic [ale_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [ale_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [ale_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

    // traffic mix of a random phase
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} traffic_mix_t;

    typedef struct {
        logic                          ok;
        logic [ale_pkg::POS_W-1:0]     pos;
        logic [ale_pkg::COUNT_W-1:0]   count;
    } list_result_t;

    typedef struct {
        logic [ale_pkg::OP_W-1:0]           op;
        logic signed [ale_pkg::VALUE_W-1:0] value;
        logic [ale_pkg::POS_W-1:0]          pos;
        logic                               want_ok;
        int                                 want_pos;
        int                                 want_count;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ale_req_if req_ch ();
    ale_rsp_if rsp_ch ();

    array_list_engine DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench copy of the list, and the results still owed by the block
    // ------------------------------------------------------------------------
    logic signed [ale_pkg::VALUE_W-1:0] list_mem [LIST_CAP];
    int                                 list_count = 0;
    list_result_t                       pending_results [$];
    stim_row_t                          directed_rows [$];
    list_result_t                       oldest;

    int     errors       = 0;
    int     sent         = 0;
    int     checked      = 0;
    int     peak_count   = 0;
    int     search_hits  = 0;
    int     full_refused = 0;
    int     long_holds   = 0;
    longint cycles       = 0;

    bit quiet        = 1'b0;   // no idling on either side
    bit sender_gaps  = 1'b1;
    bit rsp_gaps     = 1'b1;
    bit rsp_hold_req = 1'b0;   // ask the result side for one long stall

    // Applies one request to the bench list and returns what the block owes.
    // Only entries below list_count are ever looked at.
    function automatic list_result_t list_apply(
        input logic [ale_pkg::OP_W-1:0] op,
        input logic signed [ale_pkg::VALUE_W-1:0] value,
        input logic [ale_pkg::POS_W-1:0] pos);
        list_result_t r;
        int           hit;
        int           drop;
        int           k;
        r.ok  = 1'b0;
        r.pos = '0;
        hit   = -1;
        drop  = -1;
        if (op == ale_pkg::OP_SEARCH || op == ale_pkg::OP_SEARCH_DEL)
        begin
            // walk down so the lowest match wins
            for (k = list_count - 1; k >= 0; k--)
                if (list_mem[k] == value)
                    hit = k;
        end
        case (op)
            ale_pkg::OP_APPEND:
                if (list_count < LIST_CAP)
                begin
                    list_mem[list_count] = value;
                    list_count++;
                    r.ok = 1'b1;
                end
            ale_pkg::OP_DEL_LAST:
                if (list_count > 0)
                begin
                    list_count--;
                    r.ok = 1'b1;
                end
            ale_pkg::OP_DEL_AT:
                if (int'(pos) < list_count)
                begin
                    drop = int'(pos);
                    r.ok = 1'b1;
                end
            ale_pkg::OP_SEARCH:
                if (hit >= 0)
                begin
                    r.ok  = 1'b1;
                    r.pos = ale_pkg::POS_W'(hit);
                end
            ale_pkg::OP_SEARCH_DEL:
                if (hit >= 0)
                begin
                    drop  = hit;
                    r.ok  = 1'b1;
                    r.pos = ale_pkg::POS_W'(hit);
                end
            default: ;
        endcase
        if (drop >= 0)
        begin
            for (k = drop; k + 1 < list_count; k++)
                list_mem[k] = list_mem[k + 1];
            list_count--;
        end
        r.count = ale_pkg::COUNT_W'(list_count);
        return r;
    endfunction

    task automatic add_row(input logic [ale_pkg::OP_W-1:0] op,
                           input logic signed [ale_pkg::VALUE_W-1:0] value,
                           input logic [ale_pkg::POS_W-1:0] pos, input logic want_ok,
                           input int want_pos, input int want_count);
        stim_row_t row;
        row.op         = op;
        row.value      = value;
        row.pos        = pos;
        row.want_ok    = want_ok;
        row.want_pos   = want_pos;
        row.want_count = want_count;
        directed_rows.push_back(row);
    endtask

    // Offers one item from a falling edge, holds it until taken, and returns
    // at the next falling edge. The bench list is updated at the accepting
    // edge, so later picks see the list as the block will hold it. A typed-in
    // result, where given, is what the block is held to.
    task automatic issue(input logic [ale_pkg::OP_W-1:0] op,
                         input logic signed [ale_pkg::VALUE_W-1:0] value,
                         input logic [ale_pkg::POS_W-1:0] pos, input bit typed,
                         input logic want_ok, input int want_pos, input int want_count);
        list_result_t predicted;
        list_result_t written;
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.value       <= value;
        req_ch.position_in <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = list_apply(op, value, pos);
        written.ok    = want_ok;
        written.pos   = ale_pkg::POS_W'(want_pos);
        written.count = ale_pkg::COUNT_W'(want_count);
        pending_results.push_back(typed ? written : predicted);
        sent++;
        if (list_count > peak_count)
            peak_count = list_count;
        if ((op == ale_pkg::OP_SEARCH || op == ale_pkg::OP_SEARCH_DEL) && predicted.ok)
            search_hits++;
        if (op == ale_pkg::OP_APPEND && !predicted.ok)
            full_refused++;
        @(negedge clk);
    endtask

    // Random idle gap on the request side, now and then, unless quiet or sender_gaps is off.
    task automatic sender_gap();
        int n;
        if (!quiet && sender_gaps && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Holds the request side low until every owed result has come back.
    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Values lean towards a small pool and towards what is already stored,
    // so duplicates and deep matches are common.
    function automatic logic signed [ale_pkg::VALUE_W-1:0] pick_value(input bit prefer_stored);
        int t;
        if (prefer_stored && list_count > 0 && $urandom_range(0, 3) != 0)
            return list_mem[$urandom_range(0, list_count - 1)];
        case ($urandom_range(0, 3))
            0:
            begin
                t = $urandom_range(0, 15);
                return t - 8;
            end
            1:
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(ale_pkg::VALUE_W - 1){1'b0}}};
                    1: return {1'b0, {(ale_pkg::VALUE_W - 1){1'b1}}};
                    2: return -1;
                    default: return 0;
                endcase
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random ready bursts, plus one long stall on request so that
    // the output register fills and the block stops taking requests.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                rsp_hold_req = 1'b0;
                long_holds++;
            end
            else if (!quiet && rsp_gaps && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted item against the oldest owed result
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result item with nothing owed, ok=%0d pos=%0d count=%0d",
                         $time, rsp_ch.ok, rsp_ch.position_out, rsp_ch.count_out);
                errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("ok", 32'(oldest.ok), 32'(rsp_ch.ok));
                check_field("position_out", 32'(oldest.pos), 32'(rsp_ch.position_out));
                check_field("count_out", 32'(oldest.count), 32'(rsp_ch.count_out));
                checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, pending_results.size());
            $display("tb_array_list_engine: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                                 i;
        traffic_mix_t                       mix;
        int                                 grow_pct;
        int                                 r;
        logic [ale_pkg::OP_W-1:0]           op;
        logic signed [ale_pkg::VALUE_W-1:0] value;
        logic [ale_pkg::POS_W-1:0]          pos;

        req_ch.valid       = 1'b0;
        req_ch.op          = ale_pkg::OP_APPEND;
        req_ch.value       = '0;
        req_ch.position_in = '0;
        mix                = MIX_CHURN;
        grow_pct           = 40;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. Results are worked by hand; the list contents are
        // noted where they change.
        // empty list: every removal and search refused, reserved op ignored
        add_row(ale_pkg::OP_DEL_LAST,   0,            127, 1'b0, 0, 0);
        add_row(ale_pkg::OP_DEL_AT,     0,            0,   1'b0, 0, 0);
        add_row(ale_pkg::OP_SEARCH,     0,            0,   1'b0, 0, 0);
        add_row(ale_pkg::OP_SEARCH_DEL, -1,           0,   1'b0, 0, 0);
        add_row(OP_RSVD_5,              -1,           127, 1'b0, 0, 0);
        // build [min, max, -1, 0, -1]
        add_row(ale_pkg::OP_APPEND,     32'h80000000, 127, 1'b1, 0, 1);
        add_row(ale_pkg::OP_APPEND,     32'h7fffffff, 0,   1'b1, 0, 2);
        add_row(ale_pkg::OP_APPEND,     -1,           0,   1'b1, 0, 3);
        add_row(ale_pkg::OP_APPEND,     0,            0,   1'b1, 0, 4);
        add_row(ale_pkg::OP_APPEND,     -1,           0,   1'b1, 0, 5);
        // first of two matches, match at the head, no match
        add_row(ale_pkg::OP_SEARCH,     -1,           127, 1'b1, 2, 5);
        add_row(ale_pkg::OP_SEARCH,     32'h80000000, 0,   1'b1, 0, 5);
        add_row(ale_pkg::OP_SEARCH,     12345,        0,   1'b0, 0, 5);
        // index equal to count and index at the top of the field
        add_row(ale_pkg::OP_DEL_AT,     0,            5,   1'b0, 0, 5);
        add_row(ale_pkg::OP_DEL_AT,     0,            127, 1'b0, 0, 5);
        // drop the head -> [max, -1, 0, -1], then the first -1 -> [max, 0, -1]
        add_row(ale_pkg::OP_DEL_AT,     0,            0,   1'b1, 0, 4);
        add_row(ale_pkg::OP_SEARCH_DEL, -1,           0,   1'b1, 1, 3);
        add_row(ale_pkg::OP_SEARCH,     -1,           0,   1'b1, 2, 3);
        add_row(OP_RSVD_6,              0,            2,   1'b0, 0, 3);
        add_row(OP_RSVD_7,              -1,           0,   1'b0, 0, 3);
        // drop the tail by index -> [max, 0], then by remove last -> [max]
        add_row(ale_pkg::OP_DEL_AT,     0,            2,   1'b1, 0, 2);
        add_row(ale_pkg::OP_DEL_LAST,   0,            0,   1'b1, 0, 1);
        add_row(ale_pkg::OP_SEARCH_DEL, 12345,        0,   1'b0, 0, 1);
        add_row(ale_pkg::OP_SEARCH,     32'h7fffffff, 127, 1'b1, 0, 1);

        foreach (directed_rows[k])
        begin
            issue(directed_rows[k].op, directed_rows[k].value, directed_rows[k].pos, 1'b1,
                  directed_rows[k].want_ok, directed_rows[k].want_pos,
                  directed_rows[k].want_count);
            sender_gap();
        end

        // Sender waits here for every owed result before the fill.
        pause_until_drained();

        // Fill to capacity, then the refused append and the longest walks.
        while (list_count < LIST_CAP)
        begin
            issue(ale_pkg::OP_APPEND, pick_value(1'b0), ale_pkg::POS_W'($urandom), 1'b0,
                  1'b0, 0, 0);
            sender_gap();
        end
        issue(ale_pkg::OP_APPEND, pick_value(1'b0), '0, 1'b1, 1'b0, 0, LIST_CAP);
        sender_gap();
        issue(ale_pkg::OP_SEARCH, list_mem[LIST_CAP - 1], '0, 1'b0, 1'b0, 0, 0);
        issue(ale_pkg::OP_DEL_AT, 0, ale_pkg::POS_W'(LIST_CAP - 1), 1'b0, 1'b0, 0, 0);
        issue(ale_pkg::OP_DEL_AT, 0, '0, 1'b0, 1'b0, 0, 0);
        issue(ale_pkg::OP_SEARCH_DEL, list_mem[list_count - 1], '0, 1'b0, 1'b0, 0, 0);

        // Random traffic in phases of differing mix. The result side stalls
        // for a long stretch right at the start while requests keep coming.
        rsp_hold_req = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                mix = traffic_mix_t'($urandom_range(MIX_GROW, MIX_CHURN));
                case (mix)
                    MIX_GROW:   grow_pct = 65;
                    MIX_SHRINK: grow_pct = 20;
                    default:    grow_pct = 40;
                endcase
                sender_gaps = ($urandom_range(0, 3) != 0);
                rsp_gaps    = ($urandom_range(0, 3) != 0);
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS)
            begin
                pause_until_drained();
                quiet = 1'b1;
            end

            r = $urandom_range(0, 99);
            if (r < 3)
                op = ale_pkg::OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
            else if (r < grow_pct)
                op = ale_pkg::OP_APPEND;
            else
                op = ale_pkg::OP_W'($urandom_range(ale_pkg::OP_DEL_LAST,
                                                   ale_pkg::OP_SEARCH_DEL));

            value = pick_value(op == ale_pkg::OP_SEARCH || op == ale_pkg::OP_SEARCH_DEL);
            // removal indexes mostly in range, sometimes anywhere in the field
            if (op == ale_pkg::OP_DEL_AT && list_count > 0 && $urandom_range(0, 5) != 0)
                pos = ale_pkg::POS_W'($urandom_range(0, list_count - 1));
            else
                pos = ale_pkg::POS_W'($urandom);

            issue(op, value, pos, 1'b0, 1'b0, 0, 0);
            sender_gap();
        end

        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        // anything late or spurious shows up in this window
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d requests sent, %0d results checked, %0d errors",
                 sent, checked, errors);
        $display("list peaked at %0d of %0d, %0d search hits, %0d appends refused when full, %0d long stalls",
                 peak_count, LIST_CAP, search_hits, full_refused, long_holds);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_array_list_engine: PASS");
        else
            $display("tb_array_list_engine: FAIL");
        $finish;
    end

endmodule
